// ===== design/kmhd_pkg.sv =====
// ----------------------------------------------------------------------------
// kmhd_pkg
// Shared types and constants for the key matrix hold detector: matrix size
// defaults, register reset values, phase and report codes, and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package kmhd_pkg;

  // Matrix size defaults (rows 1..4, columns 1..8)
  localparam int DEF_MATRIX_ROWS = 4;
  localparam int DEF_MATRIX_COLS = 6;

  // Row/col counters cover any dimension up to 8
  localparam int POS_W = 3;
  // Width used to compare a key index against the unwired-key register
  localparam int IDX_CMP_W = 6;

  // Configuration register reset values
  localparam logic [31:0] HOLD_TIME_RESET     = 32'd2000;
  localparam logic        REPORT_ENABLE_RESET = 1'b1;
  localparam logic [4:0]  UNWIRED_KEY_RESET   = 5'd6;

  // Configuration register indexes
  localparam logic [1:0] CFG_HOLD_TIME     = 2'd0;
  localparam logic [1:0] CFG_REPORT_ENABLE = 2'd1;
  localparam logic [1:0] CFG_UNWIRED_KEY   = 2'd2;

  // Input operation codes
  localparam logic OP_KEY_CHANGE = 1'b0;
  localparam logic OP_SCAN       = 1'b1;

  // Report kinds
  localparam logic [1:0] KIND_PRESSED  = 2'd0;
  localparam logic [1:0] KIND_RELEASED = 2'd1;
  localparam logic [1:0] KIND_HOLD     = 2'd2;

  // Per-key phase
  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_PRESSED = 2'd1,
    PH_HOLD    = 2'd2
  } phase_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVENT,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  // Controller -> datapath
  typedef struct packed {
    logic capture;      // latch the input transaction
    logic capture_scan; // the latched transaction is a scan
    logic apply_event;  // update the addressed key
    logic scan_step;    // evaluate current key and advance
    logic flush_push;   // send the pending report as the last one
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic due;          // current scanned key reached hold time
    logic allowed;      // current key may report
    logic pend_valid;   // a report is waiting for its successor
    logic slot_free;    // output register can take a report this cycle
    logic last_key;     // scan is at the final key
  } status_t;

endpackage

// ===== design/kmhd_ctrl.sv =====
// ----------------------------------------------------------------------------
// kmhd_ctrl
// Sequencer for the hold detector: accepts one transaction, runs the key
// update or the matrix scan, then flushes the final report.
// ----------------------------------------------------------------------------
module kmhd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              operation,
  output logic              in_ready,
  input  kmhd_pkg::status_t status,
  output kmhd_pkg::cmd_t    cmd
);
  import kmhd_pkg::*;

  state_t state;
  state_t state_next;
  logic   stall;

  // Scan waits only when a new report meets a pending one and no free slot
  assign stall = status.due && status.allowed && status.pend_valid && !status.slot_free;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = (operation == OP_SCAN) ? ST_SCAN : ST_EVENT;
        end
      end
      ST_EVENT: begin
        state_next = ST_FLUSH;
      end
      ST_SCAN: begin
        if (!stall && status.last_key) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!status.pend_valid || status.slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    in_ready         = 1'b0;
    cmd              = '0;
    case (state)
      ST_IDLE: begin
        in_ready         = 1'b1;
        cmd.capture      = in_valid;
        cmd.capture_scan = (operation == OP_SCAN);
      end
      ST_EVENT: begin
        cmd.apply_event = 1'b1;
      end
      ST_SCAN: begin
        cmd.scan_step = !stall;
      end
      ST_FLUSH: begin
        cmd.flush_push = status.pend_valid && status.slot_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== design/kmhd_datapath.sv =====
// ----------------------------------------------------------------------------
// kmhd_datapath
// Key phase flops, press timestamp memory, configuration registers, the hold
// compare, the pending report and the output register.
// ----------------------------------------------------------------------------
module kmhd_datapath #(
  parameter int MATRIX_ROWS = kmhd_pkg::DEF_MATRIX_ROWS,
  parameter int MATRIX_COLS = kmhd_pkg::DEF_MATRIX_COLS
) (
  input  logic              clk,
  input  logic              rst,
  // configuration
  input  logic              cfg_write_en,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  // input payload
  input  logic [2:0]        key_row,
  input  logic [2:0]        key_col,
  input  logic              is_pressed,
  input  logic [31:0]       now_ms,
  // output channel
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        report_row,
  output logic [2:0]        report_col,
  output logic [1:0]        report_kind,
  output logic              last_report,
  // control
  input  kmhd_pkg::cmd_t    cmd,
  output kmhd_pkg::status_t status
);
  import kmhd_pkg::*;

  localparam int KEY_COUNT = MATRIX_ROWS * MATRIX_COLS;
  localparam int IDX_W     = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

  // Configuration
  logic [31:0] hold_limit_ms;
  logic        report_enable;
  logic [4:0]  unwired_key_index;

  // Latched transaction
  logic             pressed_r;
  logic [31:0]      now_r;
  logic             in_range;
  logic [POS_W-1:0] row_cnt;
  logic [POS_W-1:0] col_cnt;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] idx_next;

  // Key state
  phase_t      phase [KEY_COUNT];
  logic [31:0] press_mem [KEY_COUNT];
  logic [31:0] press_rdata;

  // Reports
  logic        pend_valid;
  logic [1:0]  pend_row;
  logic [2:0]  pend_col;
  logic [1:0]  pend_kind;

  logic [6:0]  ev_idx_full;
  logic [31:0] elapsed;
  logic        due;
  logic        allowed;
  logic        last_key;
  logic        slot_free;
  logic        scan_report;
  logic        scan_push;
  logic        event_report;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_limit_ms     <= HOLD_TIME_RESET;
      report_enable     <= REPORT_ENABLE_RESET;
      unwired_key_index <= UNWIRED_KEY_RESET;
    end else if (cfg_write_en) begin
      case (cfg_index)
        CFG_HOLD_TIME:     hold_limit_ms     <= cfg_data;
        CFG_REPORT_ENABLE: report_enable     <= cfg_data[0];
        CFG_UNWIRED_KEY:   unwired_key_index <= cfg_data[4:0];
        default:           ;
      endcase
    end
  end

  // Key index of an incoming key change
  assign ev_idx_full = 7'(key_row) * 7'(MATRIX_COLS) + 7'(key_col);

  // Status terms for the key at idx
  assign last_key = (row_cnt == POS_W'(MATRIX_ROWS - 1)) &&
                    (col_cnt == POS_W'(MATRIX_COLS - 1));
  assign elapsed  = now_r - press_rdata;
  assign due      = (phase[idx] == PH_PRESSED) && (elapsed >= hold_limit_ms);
  assign allowed  = report_enable &&
                    (IDX_CMP_W'(idx) != IDX_CMP_W'(unwired_key_index));
  assign slot_free = !out_valid || out_ready;

  assign scan_report  = cmd.scan_step && due && allowed;
  assign scan_push    = scan_report && pend_valid;
  assign event_report = cmd.apply_event && in_range && allowed;

  assign status.due        = due;
  assign status.allowed    = allowed;
  assign status.pend_valid = pend_valid;
  assign status.slot_free  = slot_free;
  assign status.last_key   = last_key;

  // Address for the timestamp read; the read data is registered alongside idx
  always_comb begin
    idx_next = idx;
    if (cmd.capture) begin
      idx_next = cmd.capture_scan ? '0 : ev_idx_full[IDX_W-1:0];
    end else if (cmd.scan_step && !last_key) begin
      idx_next = idx + IDX_W'(1);
    end
  end

  // Transaction latch and scan position
  always_ff @(posedge clk) begin
    idx <= idx_next;
    if (cmd.capture) begin
      pressed_r <= is_pressed;
      now_r     <= now_ms;
      in_range  <= (4'(key_row) < 4'(MATRIX_ROWS)) && (4'(key_col) < 4'(MATRIX_COLS));
      row_cnt   <= cmd.capture_scan ? '0 : key_row;
      col_cnt   <= cmd.capture_scan ? '0 : key_col;
    end else if (cmd.scan_step && !last_key) begin
      if (col_cnt == POS_W'(MATRIX_COLS - 1)) begin
        col_cnt <= '0;
        row_cnt <= row_cnt + POS_W'(1);
      end else begin
        col_cnt <= col_cnt + POS_W'(1);
      end
    end
  end

  // Press timestamp memory
  always_ff @(posedge clk) begin
    press_rdata <= press_mem[idx_next];
    if (cmd.apply_event && in_range && pressed_r) begin
      press_mem[idx] <= now_r;
    end
  end

  // Key phases
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < KEY_COUNT; i++) begin
        phase[i] <= PH_IDLE;
      end
    end else if (cmd.apply_event && in_range) begin
      phase[idx] <= pressed_r ? PH_PRESSED : PH_IDLE;
    end else if (cmd.scan_step && due) begin
      phase[idx] <= PH_HOLD;
    end
  end

  // Pending report: held back until the next one shows whether it is last
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (event_report || scan_report) begin
      pend_valid <= 1'b1;
    end else if (cmd.flush_push) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (event_report || scan_report) begin
      pend_row  <= row_cnt[1:0];
      pend_col  <= col_cnt;
      pend_kind <= cmd.apply_event ? (pressed_r ? KIND_PRESSED : KIND_RELEASED) : KIND_HOLD;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (scan_push || cmd.flush_push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (scan_push || cmd.flush_push) begin
      report_row  <= pend_row;
      report_col  <= pend_col;
      report_kind <= pend_kind;
      last_report <= cmd.flush_push;
    end
  end

endmodule

// ===== design/key_matrix_hold_detector.sv =====
// ----------------------------------------------------------------------------
// key_matrix_hold_detector
// Press / release / hold detector for a row by column key matrix.
//
//   channel  direction  handshake            payload
//   in       input      in_valid/in_ready    operation key_row key_col
//                                            is_pressed now_ms
//   out      output     out_valid/out_ready  report_row report_col
//                                            report_kind last_report
//   cfg      input      cfg_write_en         cfg_index cfg_data
//
// A key change is accepted, applied to the addressed key, then its report is flushed.
// A scan evaluates one key per cycle through the single timestamp memory read
// port, except while the output stalls, then flushes its last report.
// A report is held one step so its last flag is known; the output register
// lets a result wait while the next transaction is taken.
// Reset clears all key phases at once and restores the register defaults.
// ----------------------------------------------------------------------------
module key_matrix_hold_detector #(
  parameter int MATRIX_ROWS = kmhd_pkg::DEF_MATRIX_ROWS,
  parameter int MATRIX_COLS = kmhd_pkg::DEF_MATRIX_COLS
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_write_en,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        operation,
  input  logic [2:0]  key_row,
  input  logic [2:0]  key_col,
  input  logic        is_pressed,
  input  logic [31:0] now_ms,
  // output channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  report_row,
  output logic [2:0]  report_col,
  output logic [1:0]  report_kind,
  output logic        last_report
);
  import kmhd_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencer
  kmhd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .operation (operation),
    .in_ready  (in_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Key state and report path
  kmhd_datapath #(
    .MATRIX_ROWS (MATRIX_ROWS),
    .MATRIX_COLS (MATRIX_COLS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .key_row      (key_row),
    .key_col      (key_col),
    .is_pressed   (is_pressed),
    .now_ms       (now_ms),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .report_row   (report_row),
    .report_col   (report_col),
    .report_kind  (report_kind),
    .last_report  (last_report),
    .cmd          (cmd),
    .status       (status)
  );

endmodule
